### hdl/alpg_pkg.sv
// Shared types, constants and helpers for the antialiased line pixel generator.
// No dependencies; imported by every module of the block.
package alpg_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 16;
    localparam int COVERAGE_BITS = 8;

    localparam int QUOT_BITS    = FRAC_BITS + 1;
    localparam int SLOPE_BITS   = FRAC_BITS + 2;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);

    localparam logic [COVERAGE_BITS-1:0] COV_FULL = '1;
    localparam logic [COVERAGE_BITS-1:0] COV_HALF = {1'b1, {(COVERAGE_BITS-1){1'b0}}};

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_END    = 2'd1,
        PH_MID    = 2'd2,
        PH_SINGLE = 2'd3
    } t_phase;

    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0]    major_coord;
        logic [COORD_BITS-1:0]    minor_coord;
        logic [COVERAGE_BITS-1:0] coverage_main;
        logic [COVERAGE_BITS-1:0] coverage_next;
        logic                     x_is_major;
        logic                     last_pixel;
        logic                     no_line;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic emit;
        logic div_step;
        logic div_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic single_point;
    } t_dp_status;

    function automatic logic [COVERAGE_BITS-1:0] frac_to_cov(input logic [FRAC_BITS-1:0] frac);
        logic [FRAC_BITS+COVERAGE_BITS-1:0] ext;
        ext = {frac, {COVERAGE_BITS{1'b0}}};
        return ext[FRAC_BITS+COVERAGE_BITS-1 -: COVERAGE_BITS];
    endfunction

endpackage

### hdl/alpg_ctrl.sv
// Controller: handshake decode, load / divide / finish sequencing.
// Depends on alpg_pkg; drives alpg_dp through t_dp_cmd.
module alpg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    input  alpg_pkg::t_dp_status i_status,
    output alpg_pkg::t_dp_cmd    o_cmd
);
    import alpg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                    w_accept;

    assign o_in_ready = (r_state == ST_IDLE) && (!i_status.out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load       = w_accept && (i_command == CMD_LOAD);
        o_cmd.emit       = w_accept && (i_command == CMD_ADVANCE);
        o_cmd.div_step   = (r_state == ST_DIV);
        o_cmd.div_finish = (r_state == ST_FIN);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (o_cmd.load && !i_status.single_point) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(QUOT_BITS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hdl/alpg_dp.sv
// Datapath: endpoint ordering, restoring slope divider, minor accumulator,
// column emission and output register. Depends on alpg_pkg.
module alpg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  alpg_pkg::t_in_item   i_in_data,
    input  alpg_pkg::t_dp_cmd    i_cmd,
    output alpg_pkg::t_dp_status o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output alpg_pkg::t_out_item  o_out_data
);
    import alpg_pkg::*;

    // line state
    logic                    r_line_active;
    logic                    r_major_is_x;
    t_phase                  r_phase;
    logic [COORD_BITS-1:0]   r_cur, r_final, r_smin, r_emin;
    logic [ACC_BITS-1:0]     r_acc;
    logic [SLOPE_BITS-1:0]   r_slope;
    // divider
    logic [COORD_BITS-1:0]   r_div;
    logic [COORD_BITS:0]     r_rem;
    logic [QUOT_BITS-1:0]    r_quot;
    logic                    r_neg;
    // output
    logic                    r_out_valid;
    t_out_item               r_out_data;

    // load decode
    logic [COORD_BITS-1:0] w_adx, w_ady, w_m0a, w_m1a, w_n0a, w_n1a;
    logic [COORD_BITS-1:0] w_m0, w_m1, w_n0, w_n1, w_dmin;
    logic                  w_maj_x, w_swap, w_single;

    always_comb begin
        w_adx = (i_in_data.x_end > i_in_data.x_start) ? i_in_data.x_end - i_in_data.x_start
                                                      : i_in_data.x_start - i_in_data.x_end;
        w_ady = (i_in_data.y_end > i_in_data.y_start) ? i_in_data.y_end - i_in_data.y_start
                                                      : i_in_data.y_start - i_in_data.y_end;
        w_single = (i_in_data.x_start == i_in_data.x_end) &&
                   (i_in_data.y_start == i_in_data.y_end);
        w_maj_x = w_adx > w_ady;
        w_m0a = w_maj_x ? i_in_data.x_start : i_in_data.y_start;
        w_n0a = w_maj_x ? i_in_data.y_start : i_in_data.x_start;
        w_m1a = w_maj_x ? i_in_data.x_end   : i_in_data.y_end;
        w_n1a = w_maj_x ? i_in_data.y_end   : i_in_data.x_end;
        w_swap = w_m1a < w_m0a;
        w_m0 = w_swap ? w_m1a : w_m0a;
        w_m1 = w_swap ? w_m0a : w_m1a;
        w_n0 = w_swap ? w_n1a : w_n0a;
        w_n1 = w_swap ? w_n0a : w_n1a;
        w_dmin = (w_n1 >= w_n0) ? w_n1 - w_n0 : w_n0 - w_n1;
    end

    assign o_status.out_valid    = r_out_valid;
    assign o_status.single_point = w_single;

    // divider step: one quotient bit per cycle
    logic                  w_ge;
    logic [COORD_BITS:0]   w_rem_sub;

    assign w_ge      = r_rem >= {1'b0, r_div};
    assign w_rem_sub = w_ge ? r_rem - {1'b0, r_div} : r_rem;

    // finish: signed slope and first interior position
    logic [SLOPE_BITS-1:0] w_qs;
    logic [ACC_BITS-1:0]   w_base, w_qx, w_slope_ext;

    assign w_qs        = {1'b0, r_quot};
    assign w_base      = {1'b0, r_smin, {FRAC_BITS{1'b0}}};
    assign w_qx        = {{(ACC_BITS-QUOT_BITS){1'b0}}, r_quot};
    assign w_slope_ext = {{(ACC_BITS-SLOPE_BITS){r_slope[SLOPE_BITS-1]}}, r_slope};

    // emission
    logic                     w_end_last, w_mid_last;
    logic [COVERAGE_BITS-1:0] w_f;
    t_out_item                w_out;

    assign w_end_last = (r_final - r_cur) <= COORD_BITS'(1);
    assign w_mid_last = ({1'b0, r_cur} + 1'b1) >= {1'b0, r_final};
    assign w_f        = frac_to_cov(r_acc[FRAC_BITS-1:0]);

    always_comb begin
        w_out = '0;
        if (!r_line_active) begin
            w_out.no_line = 1'b1;
        end else begin
            w_out.x_is_major = r_major_is_x;
            case (r_phase)
                PH_SINGLE: begin
                    w_out.major_coord   = r_cur;
                    w_out.minor_coord   = r_smin;
                    w_out.coverage_main = COV_FULL;
                    w_out.last_pixel    = 1'b1;
                end
                PH_START: begin
                    w_out.major_coord   = r_cur;
                    w_out.minor_coord   = r_smin;
                    w_out.coverage_main = COV_HALF;
                end
                PH_END: begin
                    w_out.major_coord   = r_final;
                    w_out.minor_coord   = r_emin;
                    w_out.coverage_main = COV_HALF;
                    w_out.last_pixel    = w_end_last;
                end
                default: begin
                    w_out.major_coord   = r_cur;
                    w_out.minor_coord   = r_acc[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                    w_out.coverage_main = COV_FULL - w_f;
                    w_out.coverage_next = w_f;
                    w_out.last_pixel    = w_mid_last;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_line_active <= 1'b1;
            end else if (i_cmd.emit && r_line_active) begin
                if ((r_phase == PH_SINGLE) ||
                    ((r_phase == PH_END) && w_end_last) ||
                    ((r_phase == PH_MID) && w_mid_last)) begin
                    r_line_active <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= w_out;
        end
        if (i_cmd.load) begin
            r_major_is_x <= w_maj_x;
            r_phase      <= w_single ? PH_SINGLE : PH_START;
            r_cur        <= w_m0;
            r_final      <= w_m1;
            r_smin       <= w_n0;
            r_emin       <= w_n1;
            r_div        <= w_m1 - w_m0;
            r_rem        <= {1'b0, w_dmin};
            r_quot       <= '0;
            r_neg        <= w_n1 < w_n0;
        end else if (i_cmd.div_step) begin
            r_rem  <= {w_rem_sub[COORD_BITS-1:0], 1'b0};
            r_quot <= {r_quot[QUOT_BITS-2:0], w_ge};
        end else if (i_cmd.div_finish) begin
            r_slope <= r_neg ? SLOPE_BITS'(0) - w_qs : w_qs;
            r_acc   <= r_neg ? w_base - w_qx : w_base + w_qx;
        end else if (i_cmd.emit && r_line_active) begin
            case (r_phase)
                PH_START: begin
                    r_phase <= PH_END;
                end
                PH_END: begin
                    if (!w_end_last) begin
                        r_cur   <= r_cur + 1'b1;
                        r_phase <= PH_MID;
                    end
                end
                PH_MID: begin
                    r_acc <= r_acc + w_slope_ext;
                    if (!w_mid_last) begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hdl/antialiased_line_pixel_generator.sv
// Antialiased line pixel generator, top level.
// Depends on alpg_pkg, alpg_ctrl and alpg_dp.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one item per command.
//   A load item (command 0) takes two endpoints and produces no result.
//   An advance item (command 1) produces exactly one result item.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
//   advance, in order: start endpoint, end endpoint, then interior columns.
//   An advance with no active line returns an item with no_line set.
// An advance result is valid the cycle after the item is taken.
// Throughput: one advance per cycle while no load is busy; the output
//   register lets the next advance in while the previous result is taken.
// A load of distinct endpoints runs the accept, one restoring-divider step
//   per slope bit, and a finish step that forms the signed slope and the
//   first minor position; o_in_ready is low meanwhile. A load of equal
//   endpoints skips the divide.
// Reset (i_rst_n low, synchronous) drops any active line and empties the
//   output register. When the receiver stalls, the result holds and input
//   is taken only once the output slot frees.
module antialiased_line_pixel_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  alpg_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alpg_pkg::t_out_item o_out_data
);
    import alpg_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    alpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_data.command),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    alpg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### hdl/alpg_checker.sv
// Port-level checks for the antialiased line pixel generator, bound to the top.
// Depends on alpg_pkg and antialiased_line_pixel_generator.
module alpg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input alpg_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input alpg_pkg::t_out_item o_out_data
);
    import alpg_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_advance_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_data.command == CMD_ADVANCE) |=> o_out_valid)
        else $error("advance produced no result");

    a_load_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_data.command == CMD_LOAD) && (!o_out_valid || i_out_ready)
        |=> !o_out_valid)
        else $error("load produced a result");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_data.command == CMD_LOAD) &&
        ((i_in_data.x_start != i_in_data.x_end) || (i_in_data.y_start != i_in_data.y_end))
        |=> !o_in_ready)
        else $error("input taken during slope computation");

    a_no_line_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_line |->
        (o_out_data.coverage_main == '0) && !o_out_data.last_pixel)
        else $error("no_line result carries pixel data");

endmodule

bind antialiased_line_pixel_generator alpg_checker u_alpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
